FILE: src/bua_pkg.sv
// Shared types and constants of the bitmap unit allocator.
package bua_pkg;

    localparam int HINT_W   = 12;
    localparam int REL_W    = 37;
    localparam int OFF_W    = 38;
    localparam int CFG_W    = 13;
    localparam int FULL_PAD = 100;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic CFG_UNIT_COUNT = 1'b0;
    localparam logic CFG_DISCARD    = 1'b1;

    localparam logic [CFG_W-1:0] UNIT_COUNT_RESET = 13'd4096;

    typedef logic [0:0]       t_cfg_idx;
    typedef logic [CFG_W-1:0] t_cfg_data;

    typedef struct packed {
        logic              cmd;
        logic [HINT_W-1:0] start_hint;
        logic [REL_W-1:0]  release_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] unit_offset;
        logic             trim_request;
        logic [CFG_W-1:0] free_units;
    } t_out_item;

endpackage

FILE: src/bua_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bua_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/bitmap_unit_allocator_core.sv
// Bitmap unit allocator: used-bit map in RAM, rotating first-fit allocate and release.
// After reset a clearing pass zeroes the map, one word a cycle.
// Allocate: a bit-serial remainder of the hint, then a scan that reads one map word per cycle
// (64 bits at the default size), then the result. Release: a bad offset goes straight to
// the result, else its map word is read, checked and cleared; one item is in work at a time.
// Reset is synchronous and active low; the result register lets the next beat in while it waits.
module bitmap_unit_allocator_core #(
    parameter int MAX_UNITS  = 4096,
    parameter int UNIT_SHIFT = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bua_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bua_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  bua_pkg::t_cfg_idx   i_cfg_idx,
    input  bua_pkg::t_cfg_data  i_cfg_data
);
    import bua_pkg::*;

    localparam int WORD_W = (MAX_UNITS >= 128) ? 64 : 4;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int WORDS  = (MAX_UNITS + WORD_W - 1) / WORD_W;
    localparam int U_W    = $clog2(MAX_UNITS);
    localparam int AW     = U_W - BIT_W;
    localparam int N_W    = ($clog2(MAX_UNITS + 1) > CFG_W) ? $clog2(MAX_UNITS + 1) : CFG_W;
    localparam int CNT_W  = $clog2(HINT_W);

    localparam logic [AW-1:0]  LAST_WORD = AW'(WORDS - 1);
    localparam logic [N_W-1:0] N_MAX     = N_W'(MAX_UNITS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_REL_RD = 3'd4;
    localparam logic [2:0] S_REL_CK = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]        r_state;
    logic [CFG_W-1:0]  r_unit_count;
    logic              r_discard;
    logic [N_W-1:0]    r_used;
    logic [AW-1:0]     r_clr_addr;
    logic [HINT_W-1:0] r_hint;
    logic [CNT_W-1:0]  r_div_cnt;
    logic [N_W-1:0]    r_rem;
    logic [U_W-1:0]    r_base;
    logic [AW-1:0]     r_iaddr;
    logic              r_phase;
    logic              r_iss_on;
    logic              r_pend;
    logic [AW-1:0]     r_pend_addr;
    logic              r_pend_phase;
    logic              r_pend_last;
    logic [U_W-1:0]    r_rel_u;
    logic [1:0]        r_status;
    logic [OFF_W-1:0]  r_offset;
    logic              r_trim;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [N_W-1:0]    eff_n;
    logic [N_W-1:0]    uc_ext;
    logic [N_W-1:0]    n_m1;
    logic [AW-1:0]     last_w;
    logic [AW-1:0]     base_w;
    logic [N_W:0]      div_t;
    logic [N_W:0]      div_r;
    logic [N_W-1:0]    n_rem;
    logic [REL_W-1:0]  rel_id;
    logic              rel_bad;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] free_bits;
    logic              hit;
    logic [BIT_W-1:0]  hit_idx;
    logic [U_W-1:0]    hit_unit;
    logic [BIT_W-1:0]  rel_bit_idx;
    logic              rel_bit;
    logic [N_W:0]      full_units;
    logic [CFG_W-1:0]  free_now;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;

    // A unit count of zero acts as one, and one above the capacity acts as the capacity.
    assign uc_ext = N_W'(r_unit_count);
    assign eff_n  = (r_unit_count == '0) ? N_W'(1) : ((uc_ext > N_MAX) ? N_MAX : uc_ext);
    assign n_m1   = eff_n - N_W'(1);
    assign last_w = n_m1[U_W-1:BIT_W];
    assign base_w = r_base[U_W-1:BIT_W];

    // One restoring step of the hint remainder per cycle, most significant bit first.
    assign div_t = {r_rem, r_hint[r_div_cnt]};
    assign div_r = (div_t >= {1'b0, eff_n}) ? (div_t - {1'b0, eff_n}) : div_t;
    assign n_rem = div_r[N_W-1:0];

    assign rel_id  = i_in_data.release_offset >> UNIT_SHIFT;
    assign rel_bad = (|i_in_data.release_offset[UNIT_SHIFT-1:0])
                     || (rel_id >= REL_W'(eff_n));

    // Phase 0 covers units from the start up to the count, phase 1 wraps below the start.
    always_comb begin
        logic [U_W-1:0] unit;
        logic           in_range;
        for (int b = 0; b < WORD_W; b++) begin
            unit     = {r_pend_addr, BIT_W'(b)};
            in_range = r_pend_phase ? (unit < r_base)
                                    : ((unit >= r_base) && (N_W'(unit) < eff_n));
            free_bits[b] = ~rdata[b] & in_range;
        end
    end

    always_comb begin
        hit_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_idx = BIT_W'(b);
            end
        end
    end

    assign hit         = |free_bits;
    assign hit_unit    = {r_pend_addr, hit_idx};
    assign rel_bit_idx = r_rel_u[BIT_W-1:0];
    assign rel_bit     = rdata[rel_bit_idx];
    assign full_units  = {1'b0, eff_n} + (N_W + 1)'(FULL_PAD);
    assign free_now    = (r_used >= eff_n) ? '0 : CFG_W'(eff_n - r_used);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pend_addr;
        ram_wdata = rdata | (WORD_W'(1) << hit_idx);
        ram_raddr = r_iaddr;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_SCAN: begin
                ram_we = r_pend && hit;
            end
            S_REL_RD: begin
                ram_raddr = r_rel_u[U_W-1:BIT_W];
            end
            S_REL_CK: begin
                ram_we    = rel_bit;
                ram_waddr = r_rel_u[U_W-1:BIT_W];
                ram_wdata = rdata & ~(WORD_W'(1) << rel_bit_idx);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bua_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_used       <= '0;
            r_unit_count <= UNIT_COUNT_RESET;
            r_discard    <= 1'b0;
            r_pend       <= 1'b0;
            r_iss_on     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_UNIT_COUNT: r_unit_count <= i_cfg_data;
                    CFG_DISCARD:    r_discard    <= i_cfg_data[0];
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_trim   <= 1'b0;
                        r_offset <= '0;
                        r_status <= ST_OK;
                        if (i_in_data.cmd == CMD_ALLOC) begin
                            r_hint    <= i_in_data.start_hint;
                            r_div_cnt <= CNT_W'(HINT_W - 1);
                            r_rem     <= '0;
                            r_state   <= S_DIV;
                        end else begin
                            r_rel_u <= rel_id[U_W-1:0];
                            if (rel_bad) begin
                                r_status <= ST_BAD;
                                r_state  <= S_RESULT;
                            end else begin
                                r_state <= S_REL_RD;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_rem     <= n_rem;
                    r_div_cnt <= r_div_cnt - CNT_W'(1);
                    if (r_div_cnt == '0) begin
                        r_base   <= n_rem[U_W-1:0];
                        r_iaddr  <= n_rem[U_W-1:BIT_W];
                        r_phase  <= 1'b0;
                        r_iss_on <= 1'b1;
                        r_pend   <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Reads stream one word a cycle; the word issued last cycle is checked now.
                    r_pend       <= r_iss_on;
                    r_pend_addr  <= r_iaddr;
                    r_pend_phase <= r_phase;
                    r_pend_last  <= r_phase && (r_iaddr == base_w);
                    if (r_iss_on) begin
                        if (r_phase && (r_iaddr == base_w)) begin
                            r_iss_on <= 1'b0;
                        end else if (!r_phase && (r_iaddr == last_w)) begin
                            r_iaddr <= '0;
                            r_phase <= 1'b1;
                        end else begin
                            r_iaddr <= r_iaddr + AW'(1);
                        end
                    end
                    if (r_pend) begin
                        if (hit) begin
                            r_used   <= r_used + N_W'(1);
                            r_status <= ST_OK;
                            r_offset <= OFF_W'(hit_unit) << UNIT_SHIFT;
                            r_pend   <= 1'b0;
                            r_iss_on <= 1'b0;
                            r_state  <= S_RESULT;
                        end else if (r_pend_last) begin
                            r_status <= ST_FULL;
                            r_offset <= OFF_W'(full_units) << UNIT_SHIFT;
                            r_pend   <= 1'b0;
                            r_iss_on <= 1'b0;
                            r_state  <= S_RESULT;
                        end
                    end
                end
                S_REL_RD: begin
                    r_state <= S_REL_CK;
                end
                S_REL_CK: begin
                    if (rel_bit) begin
                        if (r_used != '0) begin
                            r_used <= r_used - N_W'(1);
                        end
                        r_trim   <= r_discard;
                        r_status <= ST_OK;
                    end else begin
                        r_status <= ST_BAD;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.status       <= r_status;
                        r_out.unit_offset  <= r_offset;
                        r_out.trim_request <= r_trim;
                        r_out.free_units   <= free_now;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= N_MAX)
        else $error("used count above capacity");

    a_full_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FULL)) |-> (o_out_data.free_units == '0))
        else $error("full status with free units left");

    a_trim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.trim_request) |-> (o_out_data.status == ST_OK))
        else $error("trim request on a failed beat");

    a_scan_write_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && ram_we) |=> (r_state == S_RESULT))
        else $error("scan kept running after claiming a unit");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the bitmap unit allocator core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bua_pkg::*;

    localparam int MAX_UNITS      = 4096;
    localparam int UNIT_SHIFT     = 25;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int HOLD_CYCLES    = 400;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_we    = 1'b0;
    t_cfg_idx  i_cfg_idx   = CFG_UNIT_COUNT;
    t_cfg_data i_cfg_data  = '0;

    // Shadow copy of the allocator state.
    bit              unit_used [MAX_UNITS];
    int unsigned     used_total  = 0;
    logic [CFG_W-1:0] unit_count_reg = UNIT_COUNT_RESET;
    logic            discard_reg = 1'b0;

    t_out_item   awaited_outcomes [$];
    int unsigned fail_count    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_left     = 0;

    bitmap_unit_allocator_core #(
        .MAX_UNITS  (MAX_UNITS),
        .UNIT_SHIFT (UNIT_SHIFT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned live_units();
        if (unit_count_reg == 0) begin
            return 1;
        end
        if (unit_count_reg > MAX_UNITS) begin
            return MAX_UNITS;
        end
        return 32'(unit_count_reg);
    endfunction

    // Applies one command to the shadow state and returns the outcome it should produce.
    function automatic t_out_item compute_outcome(t_in_item it);
        t_out_item        r;
        int unsigned      n;
        int unsigned      id;
        int unsigned      k;
        bit               hit;
        logic [REL_W-1:0] off;
        r   = '0;
        n   = live_units();
        hit = 1'b0;
        r.status = ST_OK;
        if (it.cmd == CMD_ALLOC) begin
            id = it.start_hint % n;
            for (k = 0; k < n && !hit; k++) begin
                if (!unit_used[id]) begin
                    unit_used[id] = 1'b1;
                    used_total++;
                    r.unit_offset = OFF_W'(id) << UNIT_SHIFT;
                    hit = 1'b1;
                end else begin
                    id = (id + 1 == n) ? 0 : id + 1;
                end
            end
            if (!hit) begin
                r.status      = ST_FULL;
                r.unit_offset = OFF_W'(n + FULL_PAD) << UNIT_SHIFT;
            end
        end else begin
            off = it.release_offset;
            id  = int'(off >> UNIT_SHIFT);
            if (off[UNIT_SHIFT-1:0] != 0 || id >= n || !unit_used[id]) begin
                r.status = ST_BAD;
            end else begin
                unit_used[id] = 1'b0;
                if (used_total > 0) begin
                    used_total--;
                end
                r.trim_request = discard_reg;
            end
        end
        r.free_units = (used_total >= n) ? '0 : CFG_W'(n - used_total);
        return r;
    endfunction

    function automatic t_in_item alloc_cmd(int unsigned hint);
        t_in_item it;
        it            = '0;
        it.cmd        = CMD_ALLOC;
        it.start_hint = HINT_W'(hint);
        return it;
    endfunction

    function automatic t_in_item release_cmd(logic [REL_W-1:0] off);
        t_in_item it;
        it                = '0;
        it.cmd            = CMD_RELEASE;
        it.release_offset = off;
        return it;
    endfunction

    // Byte offset of a used unit below the live count, or of a free one if none is used.
    function automatic logic [REL_W-1:0] held_unit_offset();
        int unsigned n;
        int unsigned id;
        int unsigned k;
        n  = live_units();
        id = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) begin
            if (unit_used[id]) begin
                break;
            end
            id = (id + 1 == n) ? 0 : id + 1;
        end
        return REL_W'(id) << UNIT_SHIFT;
    endfunction

    function automatic t_in_item random_command();
        t_in_item    it;
        int unsigned pick;
        pick              = $urandom_range(0, 99);
        it.start_hint     = HINT_W'($urandom);
        it.release_offset = REL_W'({$urandom, $urandom});
        it.cmd            = (pick < 55) ? CMD_ALLOC : CMD_RELEASE;
        if (pick >= 55 && pick < 88) begin
            it.release_offset = held_unit_offset();
        end else if (pick >= 88) begin
            case ($urandom_range(0, 3))
                0: begin
                    it.release_offset = REL_W'({$urandom, $urandom});
                end
                1: begin
                    it.release_offset = REL_W'($urandom_range(0, MAX_UNITS - 1)) << UNIT_SHIFT;
                end
                2: begin
                    it.release_offset = held_unit_offset()
                        | REL_W'($urandom_range(1, (1 << UNIT_SHIFT) - 1));
                end
                default: begin
                    it.release_offset =
                        REL_W'(live_units() + $urandom_range(0, 63)) << UNIT_SHIFT;
                end
            endcase
        end
        return it;
    endfunction

    function automatic logic [CFG_W-1:0] random_unit_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 13'd8191;
            2:       return 13'd4096;
            3:       return CFG_W'($urandom_range(0, 8191));
            default: return CFG_W'($urandom_range(1, 48));
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        awaited_outcomes.push_back(compute_outcome(it));
    endtask

    // Drops valid and waits until every pending outcome has been delivered.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_config(input logic [CFG_W-1:0] units, input logic trim_on);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_UNIT_COUNT;
        i_cfg_data <= units;
        @(posedge i_clk);
        unit_count_reg = units;
        i_cfg_idx  <= CFG_DISCARD;
        // Upper bits are junk; only bit zero of the discard register counts.
        i_cfg_data <= {(CFG_W - 1)'($urandom), trim_on};
        @(posedge i_clk);
        discard_reg = trim_on;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        if (awaited_outcomes.size() == 0) begin
            $error("result beat arrived with no outcome pending");
            fail_count++;
        end else begin
            want = awaited_outcomes.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.unit_offset !== want.unit_offset) begin
                $error("unit_offset: expected %0h, got %0h", want.unit_offset, got.unit_offset);
                fail_count++;
            end
            if (got.trim_request !== want.trim_request) begin
                $error("trim_request: expected %0d, got %0d",
                       want.trim_request, got.trim_request);
                fail_count++;
            end
            if (got.free_units !== want.free_units) begin
                $error("free_units: expected %0d, got %0d", want.free_units, got.free_units);
                fail_count++;
            end
        end
    endtask

    // Result side: check the accepted beat, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                check_beat(o_out_data);
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
            || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_corner_cases();
        send_idle_pct = 0;
        stall_pct    <= 0;
        set_config(13'd4096, 1'b0);
        send_item(alloc_cmd(0));
        send_item(alloc_cmd(MAX_UNITS - 1));
        send_item(alloc_cmd(0));
        // Scan from the top unit wraps around to the bottom of the map.
        send_item(alloc_cmd(MAX_UNITS - 1));
        send_item(release_cmd('0));
        send_item(release_cmd('0));
        send_item(release_cmd((REL_W'(1) << UNIT_SHIFT) | REL_W'(1)));
        send_item(release_cmd('1));
        settle_idle();
        set_config(13'd4096, 1'b1);
        send_item(release_cmd(REL_W'(MAX_UNITS - 1) << UNIT_SHIFT));
        settle_idle();
        set_config(13'd3, 1'b1);
        send_item(alloc_cmd(MAX_UNITS - 1));
        send_item(alloc_cmd(7));
        send_item(release_cmd(REL_W'(5) << UNIT_SHIFT));
        send_item(release_cmd(REL_W'(2) << UNIT_SHIFT));
        send_item(alloc_cmd(2));
        // A zero unit count acts as one unit; the used count now exceeds it.
        settle_idle();
        set_config(13'd0, 1'b0);
        send_item(alloc_cmd(0));
        send_item(release_cmd(REL_W'(1) << UNIT_SHIFT));
        send_item(release_cmd('0));
        send_item(alloc_cmd(MAX_UNITS - 1));
        settle_idle();
        set_config(13'd8191, 1'b1);
        send_item(alloc_cmd(MAX_UNITS - 1));
        send_item(release_cmd(REL_W'(MAX_UNITS - 1) << UNIT_SHIFT));
        send_item(release_cmd(REL_W'(2) << UNIT_SHIFT));
        send_item(release_cmd(REL_W'(1) << UNIT_SHIFT));
        send_item(release_cmd('0));
    endtask

    task automatic test_random_traffic();
        int phase;
        int blk;
        int k;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 54; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 54; end
                default: begin send_idle_pct = 7; stall_pct <= 7; end
            endcase
            for (blk = 0; blk < 2; blk++) begin
                settle_idle();
                set_config(random_unit_count(), 1'($urandom_range(0, 1)));
                for (k = 0; k < 55; k++) begin
                    send_item(random_command());
                end
            end
        end
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_output_backpressure();
        int k;
        settle_idle();
        send_idle_pct = 0;
        stall_pct    <= 0;
        set_config(13'd16, 1'b1);
        hold_left <= HOLD_CYCLES;
        for (k = 0; k < 30; k++) begin
            send_item(random_command());
        end
    endtask

    task automatic test_drain_pause();
        int k;
        send_idle_pct = 7;
        stall_pct    <= 7;
        for (k = 0; k < 10; k++) begin
            send_item(random_command());
        end
        settle_idle();
        for (k = 0; k < 10; k++) begin
            send_item(random_command());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_cases();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();
        settle_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaited_outcomes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
